>>> hdl/wfm_pkg.sv
// Shared types, register indexes and helpers for the fuzzy word match block.
// Used by the cell, the top level and the port checker; no dependencies.
`default_nettype none

package wfm_pkg;

   // Needle bytes that the two byte registers can hold
   localparam int NEEDLE_REG_BYTES = 16;
   localparam int NEEDLE_REG_BITS  = 8 * NEEDLE_REG_BYTES;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int LENGTH_W    = 5;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_NEEDLE_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEEDLE_LOW    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEEDLE_HIGH   = 2'd2;

   localparam logic [7:0] DIST_MAX = 8'hFF;

   typedef struct packed {
      logic [7:0] text_char;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0] min_distance;
      logic       found;
   } rsp_type;

   // Hand-off between neighbouring cells
   typedef struct packed {
      logic       fire;   // token: this cell works in this cycle
      logic       upd;    // 1: advance the row, 0: read only
      logic [7:0] lnew;   // left neighbour, updated value
      logic [7:0] lold;   // left neighbour, previous value (diagonal)
      logic [7:0] tail;   // row entry at the needle length
   } wfm_link_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_FINISH
   } wfm_state_type;

   function automatic logic [7:0] sat_inc(input logic [7:0] v);
      return (v == DIST_MAX) ? DIST_MAX : v + 8'd1;
   endfunction

   // Tab, line feed, vertical tab, form feed, carriage return and space
   function automatic logic is_space(input logic [7:0] c);
      return ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
   endfunction

endpackage

`default_nettype wire

>>> hdl/wfm_cell.sv
// One column of the edit distance row: holds one row entry and its needle compare.
// Depends on wfm_pkg for the link type and the saturating increment.
`default_nettype none

module wfm_cell import wfm_pkg::*; #(
   parameter int IDX = 1
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         row_clear,
   input  wire logic         active,
   input  wire logic         is_end,
   input  wire logic [7:0]   needle_byte,
   input  wire logic [7:0]   text_char,
   input  wire wfm_link_type link_in,
   output wfm_link_type      link_out
);

   logic [7:0]   dp_ff, dp_in;
   logic [7:0]   best;
   logic [7:0]   via_diag, via_up, via_left;
   wfm_link_type link_out_ff, link_out_in;

   // Minimum of substitute, delete and insert
   always_comb begin
      via_diag = (text_char == needle_byte) ? link_in.lold : sat_inc(link_in.lold);
      via_up   = sat_inc(dp_ff);
      via_left = sat_inc(link_in.lnew);
      best     = via_diag;
      if (via_up < best) begin
         best = via_up;
      end
      if (via_left < best) begin
         best = via_left;
      end
   end

   // Row entry
   always_comb begin
      priority if (row_clear) begin
         dp_in = 8'(IDX);
      end else if (link_in.fire && link_in.upd && active) begin
         dp_in = best;
      end else begin
         dp_in = dp_ff;
      end
   end

   // Hand on to the right neighbour; the cell at the needle length drops its value in tail
   always_comb begin
      link_out_in.fire = link_in.fire;
      link_out_in.upd  = link_in.upd;
      link_out_in.lnew = best;
      link_out_in.lold = dp_ff;
      if (is_end) begin
         link_out_in.tail = link_in.upd ? best : dp_ff;
      end else begin
         link_out_in.tail = link_in.tail;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dp_ff       <= 8'(IDX);
         link_out_ff <= '0;
      end else begin
         dp_ff       <= dp_in;
         link_out_ff <= link_out_in;
      end
   end

   assign link_out = link_out_ff;

endmodule

`default_nettype wire

>>> hdl/word_fuzzy_match_min_edit_distance.sv
// Top level: minimum Levenshtein distance of any word in a text to a needle.
// Depends on wfm_pkg and a chain of wfm_cell columns.
//
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_stall  req_type (text_char, last)
//   rsp_      out         rsp_valid / rsp_stall  rsp_type (min_distance, found)
//   csr_      in          csr_we                 csr_index, csr_wdata
//
// Each request is accepted, then a token walks column zero and the cell chain, then the
// finish state folds the word distance into the running minimum.
// One response leaves per request marked last; the row and minimum are then cleared.
// Reset is synchronous and brings the row back to entry j = j.
// A stalled response holds in the output register; a following last request waits.
`default_nettype none

module word_fuzzy_match_min_edit_distance import wfm_pkg::*; #(
   parameter int NEEDLE_MAX = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int LEN_W = $clog2(NEEDLE_MAX + 1);

   wfm_state_type state_ff, state_in;

   logic [LENGTH_W-1:0]        needle_length_ff;
   logic [CSR_DATA_W-1:0]      needle_low_ff, needle_high_ff;
   logic [NEEDLE_REG_BITS-1:0] needle_all;
   logic [LEN_W-1:0]           eff_len;

   req_type      req_ff;
   logic [7:0]   dp0_ff, dp0_in;
   logic         in_word_ff, in_word_in;
   logic [7:0]   best_ff, best_in;
   logic         any_ff, any_in;
   logic [7:0]   tail_ff;
   wfm_link_type link0_ff, link0_in;
   rsp_type      rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;

   wfm_link_type links [0:NEEDLE_MAX];

   logic accept, commit, out_free, row_clear;
   logic space_now, space_held, closing;
   logic [7:0] best_next;
   logic       any_next;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         needle_length_ff <= '0;
         needle_low_ff    <= '0;
         needle_high_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NEEDLE_LENGTH: needle_length_ff <= csr_wdata[LENGTH_W-1:0];
            CSR_NEEDLE_LOW:    needle_low_ff    <= csr_wdata;
            CSR_NEEDLE_HIGH:   needle_high_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign needle_all = {needle_high_ff, needle_low_ff};

   // Effective needle length, clipped to the chain length
   always_comb begin
      if (int'(needle_length_ff) > NEEDLE_MAX) begin
         eff_len = LEN_W'(NEEDLE_MAX);
      end else begin
         eff_len = LEN_W'(needle_length_ff);
      end
   end

   // Control
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign space_now  = is_space(req_data.text_char);
   assign space_held = is_space(req_ff.text_char);
   assign closing    = space_held ? in_word_ff : req_ff.last;

   always_comb begin
      state_in = state_ff;
      accept   = 1'b0;
      commit   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            accept = req_valid;
            if (req_valid) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (links[NEEDLE_MAX].fire) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!req_ff.last || out_free) begin
               commit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   // Column zero and the token that starts the sweep
   always_comb begin
      link0_in      = '0;
      link0_in.fire = accept;
      link0_in.upd  = !space_now;
      link0_in.lnew = sat_inc(dp0_ff);
      link0_in.lold = dp0_ff;
      link0_in.tail = space_now ? dp0_ff : sat_inc(dp0_ff);
   end

   // Word close and result
   always_comb begin
      best_next = (closing && (tail_ff < best_ff)) ? tail_ff : best_ff;
      any_next  = any_ff | closing;
      row_clear = commit && (closing || req_ff.last);

      dp0_in = dp0_ff;
      if (row_clear) begin
         dp0_in = 8'd0;
      end else if (accept && !space_now) begin
         dp0_in = sat_inc(dp0_ff);
      end

      best_in    = best_ff;
      any_in     = any_ff;
      in_word_in = in_word_ff;
      rsp_in     = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (commit) begin
         if (req_ff.last) begin
            best_in         = DIST_MAX;
            any_in          = 1'b0;
            in_word_in      = 1'b0;
            rsp_in.found    = any_next;
            rsp_in.min_distance = any_next ? best_next : 8'd0;
            rsp_valid_in    = 1'b1;
         end else begin
            best_in    = best_next;
            any_in     = any_next;
            in_word_in = closing ? 1'b0 : (!space_held || in_word_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dp0_ff       <= 8'd0;
         in_word_ff   <= 1'b0;
         best_ff      <= DIST_MAX;
         any_ff       <= 1'b0;
         link0_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dp0_ff       <= dp0_in;
         in_word_ff   <= in_word_in;
         best_ff      <= best_in;
         any_ff       <= any_in;
         link0_ff     <= link0_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload holding registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (links[NEEDLE_MAX].fire) begin
         tail_ff <= links[NEEDLE_MAX].tail;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Chain of columns 1 .. NEEDLE_MAX
   assign links[0] = link0_ff;

   for (genvar j = 1; j <= NEEDLE_MAX; j++) begin : g_col
      logic [7:0] nb;
      if (j <= NEEDLE_REG_BYTES) begin : g_reg
         assign nb = needle_all[(j-1)*8 +: 8];
      end else begin : g_zero
         assign nb = 8'd0;
      end

      wfm_cell #(
         .IDX (j)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .row_clear   (row_clear),
         .active      (LEN_W'(j) <= eff_len),
         .is_end      (LEN_W'(j) == eff_len),
         .needle_byte (nb),
         .text_char   (req_ff.text_char),
         .link_in     (links[j-1]),
         .link_out    (links[j])
      );
   end

endmodule

`default_nettype wire

>>> hdl/wfm_checker.sv
// Port-level checks for the fuzzy word match block, bound onto the top level.
// Depends on wfm_pkg for the request and response types.
`default_nettype none

module wfm_checker import wfm_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // A stalled response keeps its place and its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response dropped or changed");

   // A stalled request stays offered and unchanged
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request dropped or changed");

   // One request at a time: the port closes straight after a request is taken
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while the previous one is in the chain");

   // No word seen means a zero distance
   a_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.min_distance == 8'd0)
      else $error("distance reported without a word");

   // A fresh response only comes out while a request is being worked on
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response appeared with no request in progress");

endmodule

bind word_fuzzy_match_min_edit_distance wfm_checker u_wfm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

>>> tb/tb_word_fuzzy_match_min_edit_distance.sv
// Self-checking testbench for the fuzzy word match block: a clocked driver and
// monitor around a built-in edit-distance predictor, with random idling both sides.
// Depends on wfm_pkg and word_fuzzy_match_min_edit_distance.
`timescale 1ns / 1ps

module tb_word_fuzzy_match_min_edit_distance;
   import wfm_pkg::*;

   localparam int NEEDLE_MAX   = 16;
   // Two full walks of the cell chain plus margin
   localparam int DRAIN_CYCLES = 2 * (NEEDLE_MAX + 2) + 4;
   localparam int PHASES       = 8;
   localparam int PHASE_BYTES  = 130;
   localparam int LONG_WORD    = 270;
   localparam int LONG_HOLD    = 800;
   localparam int LONG_HOLD_AT = 40;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] LETTER_A = 8'h61;
   localparam logic [7:0] LETTER_D = 8'h64;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Stimulus bookkeeping
   req_type text_feed[$];
   rsp_type expected_minimums[$];
   int      bytes_sent   = 0;
   int      bytes_taken  = 0;
   int      results_seen = 0;
   int      mismatches   = 0;
   bit      quiet        = 1'b0;

   // Predictor copy of the registers and text state
   logic [LENGTH_W-1:0]   needle_len_cfg;
   logic [CSR_DATA_W-1:0] needle_lo_cfg;
   logic [CSR_DATA_W-1:0] needle_hi_cfg;
   logic [7:0]            dist_row [0:NEEDLE_MAX];
   logic                  word_open;
   logic [7:0]            best_dist;
   logic                  word_seen;

   word_fuzzy_match_min_edit_distance #(.NEEDLE_MAX(NEEDLE_MAX)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic logic [7:0] bump_sat(input logic [7:0] v);
      return (v == 8'hFF) ? 8'hFF : v + 8'd1;
   endfunction

   function automatic int live_length();
      return (needle_len_cfg > NEEDLE_MAX) ? NEEDLE_MAX : int'(needle_len_cfg);
   endfunction

   // Bytes past the two registers read as zero
   function automatic logic [7:0] needle_at(input int idx);
      if (idx < 8)
         return needle_lo_cfg[8*idx +: 8];
      if (idx < 16)
         return needle_hi_cfg[8*(idx-8) +: 8];
      return 8'd0;
   endfunction

   function automatic void clear_row();
      for (int j = 0; j <= NEEDLE_MAX; j++)
         dist_row[j] = (j > 255) ? 8'hFF : 8'(j);
   endfunction

   function automatic void clear_text();
      clear_row();
      word_open = 1'b0;
      best_dist = 8'hFF;
      word_seen = 1'b0;
   endfunction

   // Distance is read at whatever length is live when the word closes
   function automatic void close_word();
      if (dist_row[live_length()] < best_dist)
         best_dist = dist_row[live_length()];
      word_seen = 1'b1;
      word_open = 1'b0;
      clear_row();
   endfunction

   function automatic void consume_text_byte(input req_type r);
      int         n;
      logic [7:0] diag, up, best, via_up, via_left;
      rsp_type    res;
      n = live_length();
      if ((r.text_char >= CH_TAB && r.text_char <= CH_CR) || r.text_char == CH_SPACE) begin
         if (word_open)
            close_word();
      end else begin
         diag = dist_row[0];
         dist_row[0] = bump_sat(dist_row[0]);
         for (int j = 1; j <= n; j++) begin
            up       = dist_row[j];
            best     = (r.text_char == needle_at(j - 1)) ? diag : bump_sat(diag);
            via_up   = bump_sat(up);
            via_left = bump_sat(dist_row[j-1]);
            if (via_up < best)
               best = via_up;
            if (via_left < best)
               best = via_left;
            diag        = up;
            dist_row[j] = best;
         end
         word_open = 1'b1;
      end
      if (r.last) begin
         if (word_open)
            close_word();
         res.min_distance = word_seen ? best_dist : 8'd0;
         res.found        = word_seen;
         expected_minimums.push_back(res);
         clear_text();
      end
   endfunction

   // ---------------------------------------------------------------- driver

   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (!quiet && text_feed.size() > 0 && $urandom_range(0, 9) == 0) begin
            // start an idle burst, this one included; gap_left holds the rest of it
            gap_left = $urandom_range(0, 5);
            req_valid <= 1'b0;
         end else if (text_feed.size() > 0) begin
            req_data  <= text_feed.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   int stall_left = 0;
   int hold_left  = 0;
   bit long_done  = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         // one long hold-off so the output register fills and the input backs up
         if (!long_done && results_seen >= LONG_HOLD_AT) begin
            hold_left = LONG_HOLD;
            long_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 5);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   rsp_type want;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_minimums.size() == 0) begin
               $error("response with none pending: min_distance %0d found %0d",
                      rsp_data.min_distance, rsp_data.found);
               mismatches++;
            end else begin
               want = expected_minimums.pop_front();
               if (rsp_data.min_distance !== want.min_distance) begin
                  $error("min_distance: expected %0d, got %0d",
                         want.min_distance, rsp_data.min_distance);
                  mismatches++;
               end
               if (rsp_data.found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_data.found);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            bytes_taken++;
            consume_text_byte(req_data);
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic send_byte(input logic [7:0] c, input logic last);
      text_feed.push_back('{c, last});
      bytes_sent++;
   endtask

   function automatic logic [7:0] random_letter();
      return 8'($urandom_range(LETTER_A, LETTER_D));
   endfunction

   function automatic logic [63:0] letters_word();
      logic [63:0] w;
      for (int i = 0; i < 8; i++)
         w[8*i +: 8] = random_letter();
      return w;
   endfunction

   // Block idle: every request taken, every response back, chain drained
   task automatic wait_idle();
      do
         @(posedge clock);
      while (bytes_taken != bytes_sent || expected_minimums.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_NEEDLE_LENGTH: needle_len_cfg = val[LENGTH_W-1:0];
         CSR_NEEDLE_LOW:    needle_lo_cfg  = val;
         CSR_NEEDLE_HIGH:   needle_hi_cfg  = val;
         default: ;
      endcase
   endtask

   // Length goes in with random upper bits, which the register drops
   task automatic reconfigure(input logic [LENGTH_W-1:0] len,
                              input logic [63:0] lo, input logic [63:0] hi);
      logic [CSR_DATA_W-1:0] w;
      wait_idle();
      w = {$urandom, $urandom};
      w[LENGTH_W-1:0] = len;
      write_csr(CSR_NEEDLE_LENGTH, w);
      write_csr(CSR_NEEDLE_LOW, lo);
      write_csr(CSR_NEEDLE_HIGH, hi);
   endtask

   task automatic add_gap(ref req_type txt[$]);
      logic [7:0] k;
      repeat ($urandom_range(1, 2)) begin
         k = 8'($urandom_range(0, 5));
         txt.push_back('{(k == 8'd5) ? CH_SPACE : CH_TAB + k, 1'b0});
      end
   endtask

   // Mostly near-copies of the needle, else short words over a small alphabet
   task automatic add_word(ref req_type txt[$]);
      logic [7:0] w[$];
      int         n, pos;
      n = live_length();
      if (n > 0 && $urandom_range(0, 2) != 0) begin
         for (int i = 0; i < n; i++)
            w.push_back(needle_at(i));
         repeat ($urandom_range(0, 3)) begin
            pos = $urandom_range(0, w.size() - 1);
            case ($urandom_range(0, 2))
               0: w[pos] = random_letter();
               1: if (w.size() > 1) w.delete(pos);
               default: w.insert(pos, random_letter());
            endcase
         end
      end else begin
         repeat ($urandom_range(1, 8)) w.push_back(random_letter());
      end
      foreach (w[i])
         txt.push_back('{w[i], 1'b0});
   endtask

   task automatic push_text();
      req_type txt[$];
      int      words;
      if ($urandom_range(0, 9) == 0) begin
         // noise: any byte value at all
         repeat ($urandom_range(1, 12)) txt.push_back('{8'($urandom_range(0, 255)), 1'b0});
      end else begin
         words = $urandom_range(0, 4);
         if ($urandom_range(0, 3) == 0)
            add_gap(txt);
         for (int i = 0; i < words; i++) begin
            add_word(txt);
            if (i < words - 1 || $urandom_range(0, 2) == 0)
               add_gap(txt);
         end
      end
      if (txt.size() == 0)
         add_gap(txt);
      txt[txt.size()-1].last = 1'b1;
      foreach (txt[i])
         send_byte(txt[i].text_char, txt[i].last);
   endtask

   initial begin
      logic [LENGTH_W-1:0] len;
      logic [63:0]         lo, hi;
      int                  start;

      needle_len_cfg = '0;
      needle_lo_cfg  = '0;
      needle_hi_cfg  = '0;
      clear_text();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty needle after reset: distance is the word length
      send_byte("x", 1'b0);
      send_byte("y", 1'b0);
      send_byte(CH_SPACE, 1'b0);
      send_byte("c", 1'b1);
      // texts holding no word at all
      send_byte(CH_SPACE, 1'b1);
      send_byte(CH_TAB, 1'b0);
      send_byte(CH_CR, 1'b1);
      // bytes either side of the whitespace range are word bytes
      send_byte(CH_TAB - 8'd1, 1'b0);
      send_byte(CH_CR + 8'd1, 1'b1);

      // Oversized length clamps; needle of all-ones then all-zero bytes
      reconfigure(5'd31, '1, '0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(CH_SPACE, 1'b1);

      // Needle "cat", then shortened while a word is open
      reconfigure(5'd3, "tac", '1);
      send_byte("c", 1'b0);
      send_byte("a", 1'b0);
      send_byte("t", 1'b1);
      send_byte("c", 1'b0);
      send_byte("a", 1'b0);
      wait_idle();
      write_csr(CSR_NEEDLE_LENGTH, 64'd2);
      send_byte("t", 1'b1);

      // Random phases over a range of needle settings
      for (int p = 0; p < PHASES; p++) begin
         lo = letters_word();
         hi = letters_word();
         case (p)
            0: len = 5'd0;
            1: len = 5'd16;
            2: len = 5'($urandom_range(17, 31));
            5: begin
               len = 5'($urandom_range(1, 15));
               lo  = {$urandom, $urandom};
               hi  = {$urandom, $urandom};
            end
            7: len = 5'($urandom_range(1, 16));
            default: len = 5'($urandom_range(1, 15));
         endcase
         if (p == PHASES - 1)
            quiet = 1'b1;
         reconfigure(len, lo, hi);
         if (p == 3)
            write_csr(CSR_SPARE, {$urandom, $urandom});
         if (p == 0) begin
            // one word long enough to saturate the distance
            repeat (LONG_WORD) send_byte(random_letter(), 1'b0);
            send_byte(CH_SPACE, 1'b1);
         end
         start = bytes_sent;
         while (bytes_sent - start < PHASE_BYTES)
            push_text();
      end

      wait_idle();
      if (mismatches == 0)
         $display("tb_word_fuzzy_match_min_edit_distance: clean");
      else
         $display("tb_word_fuzzy_match_min_edit_distance: errors");
      $finish;
   end

   // Watchdog
   initial begin
      #4000000;
      $display("tb_word_fuzzy_match_min_edit_distance: errors");
      $finish;
   end

endmodule
